// ----- hdl/bptc_pkg.sv -----
// Shared widths, reset values, register codes and stage payload types.
package bptc_pkg;

	// Field and datapath widths
	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int DT_W    = 26;
	localparam int TEMP_W  = 20;
	localparam int TOUT_W  = 19;
	localparam int OFF_W   = 42;
	localparam int SENS_W  = 42;
	localparam int DD_W    = 18;
	localparam int SQ_W    = 36;
	localparam int CORR_W  = 40;
	localparam int PRES_W  = 32;

	// Configuration port
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	// Stream payload widths
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 56;

	// Calibration reset values
	localparam logic [COEF_W-1:0] C1_RST = 16'd40127;
	localparam logic [COEF_W-1:0] C2_RST = 16'd36924;
	localparam logic [COEF_W-1:0] C3_RST = 16'd23317;
	localparam logic [COEF_W-1:0] C4_RST = 16'd23282;
	localparam logic [COEF_W-1:0] C5_RST = 16'd33464;
	localparam logic [COEF_W-1:0] C6_RST = 16'd28312;

	// Temperature thresholds in hundredths of a degree
	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;

	// Register index codes
	typedef enum logic [2:0] {
		REG_C1_SENS      = 3'd0,
		REG_C2_OFFSET    = 3'd1,
		REG_C3_SENS_TC   = 3'd2,
		REG_C4_OFFSET_TC = 3'd3,
		REG_C5_REF_TEMP  = 3'd4,
		REG_C6_TEMP_COEF = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] c3;
		logic [COEF_W-1:0] c4;
		logic [COEF_W-1:0] c5;
		logic [COEF_W-1:0] c6;
	} coef_t;

	// First-order terms
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic [DD_W-1:0]          dd;
	} first_t;

	// Terms after cold correction
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp_out;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} comp_t;

	typedef struct packed {
		logic signed [PRES_W-1:0] pressure_pa;
		logic signed [TOUT_W-1:0] temperature_centi;
	} result_t;

endpackage

// ----- hdl/bptc_cfg.sv -----
// Calibration coefficient registers behind the APB-style port.
module bptc_cfg
	import bptc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output coef_t             coef
);

	logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);

	// Write the addressed coefficient, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= C1_RST;
			c2_q <= C2_RST;
			c3_q <= C3_RST;
			c4_q <= C4_RST;
			c5_q <= C5_RST;
			c6_q <= C6_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_C1_SENS:      c1_q <= pwdata[COEF_W-1:0];
				REG_C2_OFFSET:    c2_q <= pwdata[COEF_W-1:0];
				REG_C3_SENS_TC:   c3_q <= pwdata[COEF_W-1:0];
				REG_C4_OFFSET_TC: c4_q <= pwdata[COEF_W-1:0];
				REG_C5_REF_TEMP:  c5_q <= pwdata[COEF_W-1:0];
				REG_C6_TEMP_COEF: c6_q <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed coefficient
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_C1_SENS:      prdata = {{(APB_DW-COEF_W){1'b0}}, c1_q};
			REG_C2_OFFSET:    prdata = {{(APB_DW-COEF_W){1'b0}}, c2_q};
			REG_C3_SENS_TC:   prdata = {{(APB_DW-COEF_W){1'b0}}, c3_q};
			REG_C4_OFFSET_TC: prdata = {{(APB_DW-COEF_W){1'b0}}, c4_q};
			REG_C5_REF_TEMP:  prdata = {{(APB_DW-COEF_W){1'b0}}, c5_q};
			REG_C6_TEMP_COEF: prdata = {{(APB_DW-COEF_W){1'b0}}, c6_q};
			default:          prdata = '0;
		endcase
	end

	assign coef = '{c1: c1_q, c2: c2_q, c3: c3_q, c4: c4_q, c5: c5_q, c6: c6_q};

endmodule

// ----- hdl/bptc_first.sv -----
// Stages 1-3: dT, the four dT products, then TEMP, OFF, SENS and dT^2/2^31.
module bptc_first
	import bptc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  coef_t            coef,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [RAW_W-1:0] d1,
	input  logic [RAW_W-1:0] d2,
	output logic             out_valid,
	input  logic             out_ready,
	output first_t           out_data
);

	localparam int PC_W = DT_W + COEF_W + 1;
	localparam int PD_W = 2 * DT_W;

	logic vld_s1, vld_s2, vld_s3;
	logic en_s1, en_s2, en_s3;

	logic [RAW_W-1:0]         d1_s1, d1_s2;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [DT_W-1:0]   dt_c;
	logic signed [PC_W-1:0]   p6_c, p4_c, p3_c;
	logic signed [PC_W-1:0]   p6_s2, p4_s2, p3_s2;
	logic signed [PD_W-1:0]   pdd_c, pdd_s2;
	logic signed [PC_W-1:0]   p6_adj, p4_adj, p3_adj;
	first_t                   first_c, first_s3;

	// Advance a stage when it is empty or its successor advances
	assign en_s3    = !vld_s3 || out_ready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: dT = D2 - C5*256
	assign dt_c = $signed({2'b00, d2}) - $signed({2'b00, coef.c5, 8'h00});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= d1;
			dt_s1 <= dt_c;
		end
	end

	// Stage 2: products of dT
	assign p6_c  = dt_s1 * $signed({1'b0, coef.c6});
	assign p4_c  = dt_s1 * $signed({1'b0, coef.c4});
	assign p3_c  = dt_s1 * $signed({1'b0, coef.c3});
	assign pdd_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			d1_s2  <= d1_s1;
			p6_s2  <= p6_c;
			p4_s2  <= p4_c;
			p3_s2  <= p3_c;
			pdd_s2 <= pdd_c;
		end
	end

	// Stage 3: shifts that round toward zero, plus the constant terms
	assign p6_adj = p6_s2 + (p6_s2[PC_W-1] ? PC_W'(23'h7FFFFF) : '0);
	assign p4_adj = p4_s2 + (p4_s2[PC_W-1] ? PC_W'(7'h7F) : '0);
	assign p3_adj = p3_s2 + (p3_s2[PC_W-1] ? PC_W'(8'hFF) : '0);

	always_comb begin
		first_c.d1   = d1_s2;
		first_c.temp = TEMP_W'(p6_adj >>> 23) + TEMP_REF;
		first_c.off  = $signed({{(OFF_W-COEF_W-16){1'b0}}, coef.c2, 16'h0000})
		             + OFF_W'(p4_adj >>> 7);
		first_c.sens = $signed({{(SENS_W-COEF_W-15){1'b0}}, coef.c1, 15'h0000})
		             + SENS_W'(p3_adj >>> 8);
		first_c.dd   = pdd_s2[31 +: DD_W];
	end

	always_ff @(posedge clk) begin
		if (en_s3) first_s3 <= first_c;
	end

	assign out_valid = vld_s3;
	assign out_data  = first_s3;

endmodule

// ----- hdl/bptc_cold.sv -----
// Stages 4-6: second-order correction below 20 C and below -15 C.
module bptc_cold
	import bptc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  first_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output comp_t  out_data
);

	logic vld_s4, vld_s5, vld_s6;
	logic en_s4, en_s5, en_s6;

	logic signed [TEMP_W-1:0]   t_c, u_c, tout_c;
	logic signed [2*TEMP_W-1:0] tt_full, uu_full;
	logic                       cold_c, vlow_c;

	logic [RAW_W-1:0]         d1_s4, d1_s5;
	logic signed [TEMP_W-1:0] tout_s4, tout_s5;
	logic signed [OFF_W-1:0]  off_s4, off_s5;
	logic signed [SENS_W-1:0] sens_s4, sens_s5;
	logic [SQ_W-1:0]          tt_s4, uu_s4;
	logic                     cold_s4, vlow_s4;

	logic [CORR_W-1:0] tt5, uu7, uu11, off2_c, sens2_c;
	logic [CORR_W-1:0] off2_s5, sens2_s5;
	comp_t             comp_s6;

	// Advance a stage when it is empty or its successor advances
	assign en_s6    = !vld_s6 || out_ready;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s4) vld_s4 <= in_valid;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 4: squares of the offsets from both thresholds, corrected temperature
	assign t_c     = in_data.temp - TEMP_REF;
	assign u_c     = in_data.temp - TEMP_VLOW;
	assign tt_full = t_c * t_c;
	assign uu_full = u_c * u_c;
	assign cold_c  = in_data.temp < TEMP_REF;
	assign vlow_c  = in_data.temp < TEMP_VLOW;
	assign tout_c  = cold_c ? in_data.temp - $signed({2'b00, in_data.dd}) : in_data.temp;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d1_s4   <= in_data.d1;
			tout_s4 <= tout_c;
			off_s4  <= in_data.off;
			sens_s4 <= in_data.sens;
			tt_s4   <= tt_full[SQ_W-1:0];
			uu_s4   <= uu_full[SQ_W-1:0];
			cold_s4 <= cold_c;
			vlow_s4 <= vlow_c;
		end
	end

	// Stage 5: OFF2 and SENS2 from shift-and-add multiples
	assign tt5  = (CORR_W'(tt_s4) << 2) + CORR_W'(tt_s4);
	assign uu7  = (CORR_W'(uu_s4) << 3) - CORR_W'(uu_s4);
	assign uu11 = (CORR_W'(uu_s4) << 3) + (CORR_W'(uu_s4) << 1) + CORR_W'(uu_s4);

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			off2_c  = (tt5 >> 1) + (vlow_s4 ? uu7 : '0);
			sens2_c = (tt5 >> 2) + (vlow_s4 ? (uu11 >> 1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			d1_s5    <= d1_s4;
			tout_s5  <= tout_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
		end
	end

	// Stage 6: subtract the corrections
	always_ff @(posedge clk) begin
		if (en_s6) begin
			comp_s6.d1       <= d1_s5;
			comp_s6.temp_out <= tout_s5;
			comp_s6.off      <= off_s5 - $signed({{(OFF_W-CORR_W){1'b0}}, off2_s5});
			comp_s6.sens     <= sens_s5 - $signed({{(SENS_W-CORR_W){1'b0}}, sens2_s5});
		end
	end

	assign out_valid = vld_s6;
	assign out_data  = comp_s6;

endmodule

// ----- hdl/bptc_press.sv -----
// Stages 7-10: pressure from split D1*SENS products, with output register.
module bptc_press
	import bptc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  comp_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	localparam int LO_W  = 21;
	localparam int HI_W  = SENS_W - LO_W;
	localparam int PL_W  = RAW_W + LO_W;
	localparam int PH_W  = RAW_W + 1 + HI_W;
	localparam int Q_W   = PH_W + 1;
	localparam int X_W   = Q_W + 1;
	localparam int P_SH  = 15;

	logic vld_s7, vld_s8, vld_s9, vld_s10;
	logic en_s7, en_s8, en_s9, en_s10;

	logic [PL_W-1:0]          pl_c, pl_s7;
	logic signed [PH_W-1:0]   ph_c, ph_s7;
	logic                     neg_s7;
	logic signed [OFF_W-1:0]  off_s7, off_s8;
	logic signed [TEMP_W-1:0] tout_s7, tout_s8, tout_s9;
	logic signed [Q_W-1:0]    q_c, q_s8;
	logic signed [X_W-1:0]    x_s9, x_adj;
	result_t                  res_s10;

	// Advance a stage when it is empty or its successor advances
	assign en_s10   = !vld_s10 || out_ready;
	assign en_s9    = !vld_s9 || en_s10;
	assign en_s8    = !vld_s8 || en_s9;
	assign en_s7    = !vld_s7 || en_s8;
	assign in_ready = en_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (en_s7)  vld_s7  <= in_valid;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
		end
	end

	// Stage 7: D1 times the low and high halves of SENS
	assign pl_c = in_data.d1 * in_data.sens[LO_W-1:0];
	assign ph_c = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[SENS_W-1:LO_W]);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			pl_s7   <= pl_c;
			ph_s7   <= ph_c;
			neg_s7  <= in_data.sens[SENS_W-1];
			off_s7  <= in_data.off;
			tout_s7 <= in_data.temp_out;
		end
	end

	// Stage 8: D1*SENS/2^21 rounded toward zero
	assign q_c = Q_W'(ph_s7)
	           + $signed({{(Q_W-PL_W+LO_W){1'b0}}, pl_s7[PL_W-1:LO_W]})
	           + $signed({{(Q_W-1){1'b0}}, neg_s7 && (pl_s7[LO_W-1:0] != '0)});

	always_ff @(posedge clk) begin
		if (en_s8) begin
			q_s8    <= q_c;
			off_s8  <= off_s7;
			tout_s8 <= tout_s7;
		end
	end

	// Stage 9: subtract OFF
	always_ff @(posedge clk) begin
		if (en_s9) begin
			x_s9    <= X_W'(q_s8) - X_W'(off_s8);
			tout_s9 <= tout_s8;
		end
	end

	// Stage 10: divide by 2^15 toward zero, keep the low 32 bits
	assign x_adj = x_s9 + (x_s9[X_W-1] ? X_W'(15'h7FFF) : '0);

	always_ff @(posedge clk) begin
		if (en_s10) begin
			res_s10.pressure_pa       <= x_adj[P_SH +: PRES_W];
			res_s10.temperature_centi <= tout_s9[TOUT_W-1:0];
		end
	end

	assign out_valid = vld_s10;
	assign out_data  = res_s10;

endmodule

// ----- hdl/baro_pressure_temp_compensation.sv -----
// A request passes stages 1 to 10 in order; its result is held in the stage-10 register.
// Throughput: one request per cycle while results are taken; ten pipeline stages with per-stage
// valid bits, each stage advancing when empty or when its successor moves.
// A stalled result holds the pipeline; empty stages behind it still take requests.
// Reset: arst_n clears all valid bits and loads the calibration reset values.
module baro_pressure_temp_compensation
	import bptc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// s_tdata: raw_pressure [23:0], raw_temperature [47:24]
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	// m_tdata: temperature_centi [18:0], pressure_pa [50:19], zeros above
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	coef_t   coef;
	logic    f_valid, f_ready;
	first_t  f_data;
	logic    c_valid, c_ready;
	comp_t   c_data;
	result_t res;

	assign pready = 1'b1;

	bptc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.coef    (coef)
	);

	bptc_first u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.d1        (s_tdata[RAW_W-1:0]),
		.d2        (s_tdata[2*RAW_W-1:RAW_W]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	bptc_cold u_cold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_data  (c_data)
	);

	bptc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_data   (c_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// Pack the result, temperature in the low bits
	assign m_tdata = {{(M_DATA_W-PRES_W-TOUT_W){1'b0}}, res.pressure_pa, res.temperature_centi};

endmodule

// ----- sim/bptc_checker.sv -----
// Checker for the compensation block: tracks calibration writes, predicts results, compares them.
module bptc_checker
	import bptc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// s_tdata: raw_pressure [23:0], raw_temperature [47:24]
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata: temperature_centi [18:0], pressure_pa [50:19], zeros above
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic [APB_DW-1:0]   prdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RES_W = PRES_W + TOUT_W;

	// Calibration copy and readings still waiting for their result
	coef_t   coef;
	result_t compensated_q[$];

	// Compensate one reading pair with 64-bit signed terms, truncating division
	function automatic result_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw,
			coef_t k);
		longint d1, d2, dt, tc, off, sens, off2, sens2, dtemp, ctemp, tout, pres;
		result_t r;
		d1   = {40'd0, d1_raw};
		d2   = {40'd0, d2_raw};
		dt   = d2 - longint'(k.c5) * 256;
		tc   = 2000 + dt * longint'(k.c6) / 8388608;
		off  = longint'(k.c2) * 65536 + longint'(k.c4) * dt / 128;
		sens = longint'(k.c1) * 32768 + longint'(k.c3) * dt / 256;
		tout = tc;
		// Cold correction uses the uncorrected temperature
		if (tc < 2000) begin
			dtemp = tc - 2000;
			off2  = 5 * dtemp * dtemp / 2;
			sens2 = 5 * dtemp * dtemp / 4;
			if (tc < -1500) begin
				ctemp = tc + 1500;
				off2  = off2 + 7 * ctemp * ctemp;
				sens2 = sens2 + 11 * ctemp * ctemp / 2;
			end
			off  = off - off2;
			sens = sens - sens2;
			tout = tc - dt * dt / 64'sd2147483648;
		end
		pres = (d1 * sens / 2097152 - off) / 32768;
		r.temperature_centi = tout[TOUT_W-1:0];
		r.pressure_pa       = pres[PRES_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t           want;
		result_t           got;
		logic [APB_DW-1:0] rd_want;
		bit                rd_known;
		int                errs;
		if (!arst_n) begin
			coef.c1 <= C1_RST;
			coef.c2 <= C2_RST;
			coef.c3 <= C3_RST;
			coef.c4 <= C4_RST;
			coef.c5 <= C5_RST;
			coef.c6 <= C6_RST;
			compensated_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;

			// Track calibration writes, check read data
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[4:2])
						REG_C1_SENS:      coef.c1 <= pwdata[COEF_W-1:0];
						REG_C2_OFFSET:    coef.c2 <= pwdata[COEF_W-1:0];
						REG_C3_SENS_TC:   coef.c3 <= pwdata[COEF_W-1:0];
						REG_C4_OFFSET_TC: coef.c4 <= pwdata[COEF_W-1:0];
						REG_C5_REF_TEMP:  coef.c5 <= pwdata[COEF_W-1:0];
						REG_C6_TEMP_COEF: coef.c6 <= pwdata[COEF_W-1:0];
						default: ;
					endcase
				end else begin
					rd_known = 1'b1;
					rd_want  = '0;
					case (paddr[4:2])
						REG_C1_SENS:      rd_want[COEF_W-1:0] = coef.c1;
						REG_C2_OFFSET:    rd_want[COEF_W-1:0] = coef.c2;
						REG_C3_SENS_TC:   rd_want[COEF_W-1:0] = coef.c3;
						REG_C4_OFFSET_TC: rd_want[COEF_W-1:0] = coef.c4;
						REG_C5_REF_TEMP:  rd_want[COEF_W-1:0] = coef.c5;
						REG_C6_TEMP_COEF: rd_want[COEF_W-1:0] = coef.c6;
						default:          rd_known = 1'b0;
					endcase
					if (rd_known && prdata !== rd_want) begin
						if (fail_count + errs < 10)
							$display("checker: read of reg %0d exp %h got %h", paddr[4:2],
								rd_want, prdata);
						errs++;
					end
				end
			end

			// Predict each accepted request
			if (s_tvalid && s_tready)
				compensated_q.push_back(compensate(s_tdata[RAW_W-1:0],
					s_tdata[2*RAW_W-1:RAW_W], coef));

			// Compare each accepted result with the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata[RES_W-1:0];
				if (compensated_q.size() == 0) begin
					if (fail_count + errs < 10)
						$display("checker: result %h with no request waiting", m_tdata);
					errs++;
				end else begin
					want = compensated_q.pop_front();
					if (got.temperature_centi !== want.temperature_centi
							|| got.pressure_pa !== want.pressure_pa
							|| m_tdata[M_DATA_W-1:RES_W] !== '0) begin
						if (fail_count + errs < 10)
							$display("checker: temp exp %0d got %0d, pres exp %0d got %0d, pad %h",
								want.temperature_centi, got.temperature_centi,
								want.pressure_pa, got.pressure_pa,
								m_tdata[M_DATA_W-1:RES_W]);
						errs++;
					end
				end
			end

			fail_count <= fail_count + errs;
			pending    <= compensated_q.size();
		end
	end

endmodule

// ----- sim/baro_pressure_temp_compensation_tb.sv -----
// Testbench top: drives readings and calibration writes, gives the verdict.
module baro_pressure_temp_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bptc_pkg::*;

	// Register slots beyond the last coefficient, writes there are dropped
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 210;
	localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;
	localparam logic [RAW_W-1:0] RAW_MID = 24'h800000;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [APB_AW-1:0]   paddr    = '0;
	logic [APB_DW-1:0]   pwdata   = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	int                  fail_count;
	int                  pending;

	bit          no_idle    = 1'b0;
	int          send_calm  = 0;
	int          stall_left = 0;
	int          calm_left  = 0;
	logic [15:0] cur_c5     = C5_RST;

	always #5 clk = ~clk;

	baro_pressure_temp_compensation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bptc_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Bound the run
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Stall the result side in bursts, with calm stretches between
	always @(posedge clk) begin
		if (no_idle) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (calm_left == 0 && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
			if (calm_left > 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(0, 40) == 0)
				calm_left <= $urandom_range(20, 120);
		end
	end

	// Present one reading pair, hold it until accepted
	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		if (!no_idle) begin
			if (send_calm > 0) begin
				send_calm--;
			end else if ($urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else if ($urandom_range(0, 30) == 0) begin
				send_calm = $urandom_range(20, 120);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {d2, d1};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every request has its result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One APB transfer: setup cycle, then access until pready
	task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom_range(0, 65535)), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Read back every slot; the checker compares the coefficients
	task automatic read_back_all();
		apb_xfer(1'b0, REG_C1_SENS, '0);
		apb_xfer(1'b0, REG_C2_OFFSET, '0);
		apb_xfer(1'b0, REG_C3_SENS_TC, '0);
		apb_xfer(1'b0, REG_C4_OFFSET_TC, '0);
		apb_xfer(1'b0, REG_C5_REF_TEMP, '0);
		apb_xfer(1'b0, REG_C6_TEMP_COEF, '0);
		apb_xfer(1'b0, REG_SPARE_6, '0);
		apb_xfer(1'b0, REG_SPARE_7, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load a full coefficient set, poke a spare slot, read everything back
	task automatic load_coefs(input logic [15:0] c1, input logic [15:0] c2,
			input logic [15:0] c3, input logic [15:0] c4,
			input logic [15:0] c5, input logic [15:0] c6);
		apb_xfer(1'b1, REG_C1_SENS, c1);
		apb_xfer(1'b1, REG_C2_OFFSET, c2);
		apb_xfer(1'b1, REG_C3_SENS_TC, c3);
		apb_xfer(1'b1, REG_C4_OFFSET_TC, c4);
		apb_xfer(1'b1, REG_C5_REF_TEMP, c5);
		apb_xfer(1'b1, REG_C6_TEMP_COEF, c6);
		apb_xfer(1'b1, $urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
			16'($urandom_range(0, 65535)));
		cur_c5 = c5;
		read_back_all();
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Random raw reading, biased to extremes now and then
	function automatic logic [RAW_W-1:0] rand_raw();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(0, 1) ? RAW_MAX : '0;
			1:       return RAW_W'($urandom_range(0, 4095));
			default: return RAW_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	initial begin
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		int               near;
		logic [15:0]      k [6];

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: read them back, then field extremes
		read_back_all();
		send_reading('0, '0);
		send_reading(RAW_MAX, RAW_MAX);
		send_reading(RAW_MAX, '0);
		send_reading('0, RAW_MAX);
		send_reading(RAW_MID, 24'd8566784);
		send_reading(24'h555555, 24'hAAAAAA);
		wait_drained();

		// Scale of one count per 256 makes the temperature thresholds exact
		load_coefs(C1_RST, C2_RST, C3_RST, C4_RST, 16'h8000, 16'h8000);
		send_reading(RAW_MAX, RAW_MID);              // exactly 20 C
		send_reading(RAW_MAX, RAW_MID - 24'd255);    // truncates back to 20 C
		send_reading(RAW_MAX, RAW_MID - 24'd256);    // first cold step
		send_reading(RAW_MID, RAW_MID - 24'd896000); // exactly -15 C, cold only
		send_reading(RAW_MID, RAW_MID - 24'd896255); // still -15 C
		send_reading(RAW_MAX, RAW_MID - 24'd896256); // first very cold step
		send_reading(RAW_MAX, '0);                   // deepest cold
		send_reading('0, RAW_MAX);                   // hottest
		send_reading(24'h000001, RAW_MID - 24'd1);
		wait_drained();

		// Random phases over several coefficient sets
		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < 6; i++)
				k[i] = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : rand_coef();
			load_coefs(k[0], k[1], k[2], k[3], k[4], k[5]);
			if (ph == PHASES - 1)
				no_idle = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				d1 = rand_raw();
				if ($urandom_range(0, 3) == 0) begin
					// Around the reference temperature reading
					near = int'(cur_c5) * 256 + int'($urandom_range(0, 2097152)) - 1048576;
					if (near < 0)
						near = 0;
					if (near > int'(RAW_MAX))
						near = int'(RAW_MAX);
					d2 = near[RAW_W-1:0];
				end else begin
					d2 = rand_raw();
				end
				send_reading(d1, d2);
			end
			wait_drained();
		end

		// Let the pipeline settle, then report
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
